@@ hw/rtl/fdvq_pkg.sv @@
`default_nettype none
package fdvq_pkg;

  localparam int FLOWS  = 2048;
  localparam int FLOW_W = $clog2(FLOWS);
  localparam int CNT_W  = FLOW_W + 1;
  localparam int LVL_W  = 32;
  localparam int THR_W  = 24;
  localparam int FAC_W  = 10;
  localparam int VEC_W  = 9;
  localparam int SIZE_W = 16;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 3;

  localparam logic [1:0] OP_DRAIN  = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_EOV    = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [IDX_W-1:0] REG_INIT_THR = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_THR  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_THR  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEC_FAC  = 3'd3;
  localparam logic [IDX_W-1:0] REG_INC_FAC  = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_VEC  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [THR_W-1:0] RST_INIT_THR = 24'd131072;
  localparam logic [THR_W-1:0] RST_MIN_THR  = 24'd2621;
  localparam logic [THR_W-1:0] RST_MAX_THR  = 24'd13107200;
  localparam logic [FAC_W-1:0] RST_DEC_FAC  = 10'd128;
  localparam logic [FAC_W-1:0] RST_INC_FAC  = 10'd307;
  localparam logic [VEC_W-1:0] RST_MAX_VEC  = 9'd256;
  localparam logic [VEC_W-1:0] VEC_SAT      = 9'd511;

  typedef struct packed {
    logic [1:0]        op;
    logic [10:0]       flow;
    logic [SIZE_W-1:0] size;
    logic [LVL_W-1:0]  elapsed;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic [11:0]       backlogged;
    logic [THR_W-1:0]  threshold;
    logic [LVL_W-1:0]  flow_level;
  } out_t;

endpackage
`default_nettype wire

@@ hw/rtl/fdvq_ram.sv @@
`default_nettype none
module fdvq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/fair_drop_virtual_queue_unit.sv @@
`default_nettype none
// Fair-drop virtual queue. Per-flow fluid levels live in a 2048x32 level RAM,
// the ring of backlogged flows in a 2048x11 ring RAM.
// in_data (op, flow, size, elapsed) moves on a valid/ready channel; each
// input beat yields exactly one out_data beat (accepted, backlogged,
// threshold, flow_level) on a valid/ready channel.
// One item is in flight at a time; in_ready is high only when idle.
// Packet: level RAM read, update, result; the next item can be taken once
// the result has been registered.
// End of vector: threshold multiply, clamp, result.
// Drain: per water-filling pass, bit-serial division of the credit by the
// backlog count, then per backlogged flow a ring read, level read and level
// write, and finally the result. A drain with an empty ring goes straight
// to the result.
// The result sits in an output register. While the receiver stalls, the
// next item is processed and then waits in its result state, with in_ready
// low, until the output register frees.
// Reset: a clearing pass writes zero to all 2048 level entries, one per
// cycle, before in_ready rises; config writes are taken during it.
// cfg_we/cfg_index/cfg_data write one register per cycle, no wait.
module fair_drop_virtual_queue_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fdvq_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fdvq_pkg::out_t                     out_data,
  input  wire logic                          cfg_we,
  input  wire logic [fdvq_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [fdvq_pkg::CFG_W-1:0]    cfg_data
);

  localparam int FW = fdvq_pkg::FLOW_W;
  localparam int CW = fdvq_pkg::CNT_W;
  localparam int LW = fdvq_pkg::LVL_W;
  localparam int TW = fdvq_pkg::THR_W;
  localparam int PW = fdvq_pkg::LVL_W + fdvq_pkg::FAC_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_P_RD, S_P_UPD, S_D_START, S_D_DIV, S_D_RDR, S_D_RDL,
    S_D_UPD, S_A_MUL, S_A_FIN, S_OUT
  } state_t;

  state_t state;

  logic [TW-1:0] min_thr, max_thr;
  logic [fdvq_pkg::FAC_W-1:0] dec_fac, inc_fac;
  logic [fdvq_pkg::VEC_W-1:0] max_vec, vec_cnt;
  // a full vector may scale the threshold past 24 bits; only the low bits
  // are reported
  logic [LW-1:0] thr;
  logic [FW-1:0] head, tail, clr_cnt, cur_flow;
  logic [CW-1:0] backlog, prev, k;
  fdvq_pkg::in_t item;
  logic          res_acc;
  logic [LW-1:0] res_lvl;
  logic [LW-1:0] credit, quo, share;
  logic [CW-1:0] rem;
  logic [4:0]    div_cnt;
  logic [PW-1:0] prod;
  logic          full;

  // memories
  logic          lvl_we;
  logic [FW-1:0] lvl_waddr, lvl_raddr;
  logic [LW-1:0] lvl_wdata, lvl_rdata;
  logic          ring_we;
  logic [FW-1:0] ring_wdata, ring_rdata;

  fdvq_ram #(.WIDTH(LW), .DEPTH(fdvq_pkg::FLOWS)) u_level (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  fdvq_ram #(.WIDTH(FW), .DEPTH(fdvq_pkg::FLOWS)) u_ring (
    .clk(clk), .we(ring_we), .waddr(tail), .wdata(ring_wdata),
    .raddr(head), .rdata(ring_rdata)
  );

  // packet update
  logic [LW:0]   p_sum;
  logic [LW-1:0] p_new;
  logic          p_ok, p_join;
  always_comb begin
    p_sum  = {1'b0, lvl_rdata} + {{(LW+1-fdvq_pkg::SIZE_W){1'b0}}, item.size};
    p_new  = p_sum[LW] ? {LW{1'b1}} : p_sum[LW-1:0];
    p_ok   = lvl_rdata <= thr;
    p_join = p_ok && (lvl_rdata == '0) && (p_new != '0);
  end

  // drain update
  logic          d_keep;
  logic [LW-1:0] d_new;
  logic [CW-1:0] d_backlog;
  always_comb begin
    d_keep    = lvl_rdata > share;
    d_new     = d_keep ? lvl_rdata - share : '0;
    d_backlog = d_keep ? backlog : backlog - 1'b1;
  end

  // restoring division step
  logic [CW:0] rem_sh;
  logic        q_bit;
  always_comb begin
    rem_sh = {rem, quo[LW-1]};
    q_bit  = rem_sh >= {1'b0, prev};
  end

  // threshold adaptation
  logic [PW-9:0] a_sh;
  logic [PW-9:0] a_wide;
  logic [LW-1:0] a_thr;
  always_comb begin
    a_sh = prod[PW-1:8];
    if (full) begin
      a_wide = (thr > LW'(min_thr)) ? a_sh : {{(PW-8-LW){1'b0}}, thr};
      if (a_wide < (PW-8)'(min_thr)) begin
        a_wide = (PW-8)'(min_thr);
      end
    end else begin
      a_wide = {{(PW-8-LW){1'b0}}, thr};
      if (thr < LW'(max_thr)) begin
        a_wide = (a_sh[PW-9:TW] != '0) ? (PW-8)'({TW{1'b1}}) : a_sh;
      end
      if (a_wide > (PW-8)'(max_thr)) begin
        a_wide = (PW-8)'(max_thr);
      end
    end
    a_thr = a_wide[LW-1:0];
  end

  always_comb begin
    lvl_we     = 1'b0;
    lvl_waddr  = clr_cnt;
    lvl_wdata  = '0;
    lvl_raddr  = (state == S_D_RDL) ? ring_rdata : item.flow[FW-1:0];
    ring_we    = 1'b0;
    ring_wdata = item.flow[FW-1:0];
    case (state)
      S_CLR: lvl_we = 1'b1;
      S_P_UPD: begin
        lvl_we    = p_ok;
        lvl_waddr = item.flow[FW-1:0];
        lvl_wdata = p_new;
        ring_we   = p_join;
      end
      S_D_UPD: begin
        lvl_we     = 1'b1;
        lvl_waddr  = cur_flow;
        lvl_wdata  = d_new;
        ring_we    = d_keep;
        ring_wdata = cur_flow;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  function automatic logic [FW-1:0] wrap_inc(input logic [FW-1:0] p);
    return (p == FW'(fdvq_pkg::FLOWS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      min_thr  <= fdvq_pkg::RST_MIN_THR;
      max_thr  <= fdvq_pkg::RST_MAX_THR;
      dec_fac  <= fdvq_pkg::RST_DEC_FAC;
      inc_fac  <= fdvq_pkg::RST_INC_FAC;
      max_vec  <= fdvq_pkg::RST_MAX_VEC;
      thr      <= LW'(fdvq_pkg::RST_INIT_THR);
      head     <= '0;
      tail     <= '0;
      backlog  <= '0;
      vec_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      // in the result state the output register is handled below
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          fdvq_pkg::REG_INIT_THR: thr <= LW'(cfg_data);
          fdvq_pkg::REG_MIN_THR: min_thr <= cfg_data;
          fdvq_pkg::REG_MAX_THR: max_thr <= cfg_data;
          fdvq_pkg::REG_DEC_FAC: dec_fac <= cfg_data[fdvq_pkg::FAC_W-1:0];
          fdvq_pkg::REG_INC_FAC: inc_fac <= cfg_data[fdvq_pkg::FAC_W-1:0];
          fdvq_pkg::REG_MAX_VEC: max_vec <= cfg_data[fdvq_pkg::VEC_W-1:0];
          default: ;
        endcase
      end
      if (ring_we) begin
        tail <= wrap_inc(tail);
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == FW'(fdvq_pkg::FLOWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item    <= in_data;
            res_acc <= 1'b0;
            res_lvl <= '0;
            credit  <= in_data.elapsed;
            case (in_data.op)
              fdvq_pkg::OP_DRAIN:  state <= S_D_START;
              fdvq_pkg::OP_PACKET: state <= S_P_RD;
              fdvq_pkg::OP_EOV:    state <= S_A_MUL;
              default:             state <= S_OUT;
            endcase
          end
        end
        S_P_RD: state <= S_P_UPD;
        S_P_UPD: begin
          if (vec_cnt != fdvq_pkg::VEC_SAT) begin
            vec_cnt <= vec_cnt + 1'b1;
          end
          res_acc <= p_ok;
          res_lvl <= p_ok ? p_new : lvl_rdata;
          if (p_join) begin
            backlog <= backlog + 1'b1;
          end
          state <= S_OUT;
        end
        S_D_START: begin
          if (backlog == '0) begin
            state <= S_OUT;
          end else begin
            prev    <= backlog;
            quo     <= credit;
            credit  <= '0;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_D_DIV;
          end
        end
        S_D_DIV: begin
          rem     <= q_bit ? CW'(rem_sh - {1'b0, prev}) : rem_sh[CW-1:0];
          quo     <= {quo[LW-2:0], q_bit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 5'd31) begin
            k     <= '0;
            state <= S_D_RDR;
          end
        end
        S_D_RDR: begin
          share <= quo;
          state <= S_D_RDL;
        end
        S_D_RDL: begin
          cur_flow <= ring_rdata;
          head     <= wrap_inc(head);
          state    <= S_D_UPD;
        end
        S_D_UPD: begin
          backlog <= d_backlog;
          if (!d_keep) begin
            credit <= credit + (share - lvl_rdata);
          end
          k <= k + 1'b1;
          if (k + 1'b1 != prev) begin
            state <= S_D_RDR;
          end else if ((d_backlog < prev) && (d_backlog != '0)) begin
            state <= S_D_START;
          end else begin
            state <= S_OUT;
          end
        end
        S_A_MUL: begin
          full  <= vec_cnt >= max_vec;
          prod  <= thr * ((vec_cnt >= max_vec) ? dec_fac : inc_fac);
          state <= S_A_FIN;
        end
        S_A_FIN: begin
          thr     <= a_thr;
          vec_cnt <= '0;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.accepted   <= res_acc;
            out_data.backlogged <= backlog;
            out_data.threshold  <= thr[TW-1:0];
            out_data.flow_level <= res_lvl;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the ring never holds more flows than there are
  a_backlog_bound: assert property (@(posedge clk) disable iff (rst)
    backlog <= CW'(fdvq_pkg::FLOWS))
    else $error("backlog count exceeds flow count");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a division pass only runs with flows in the ring
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_D_DIV |-> prev != '0)
    else $error("division by zero backlog");

  // threshold stays put between end-of-vector items and config writes
  a_thr_stable: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_we) && $past(state) != S_A_FIN && $past(state) != S_CLR
    && !$past(rst) |-> $stable(thr))
    else $error("threshold changed unexpectedly");

endmodule
`default_nettype wire
